/* src/acc_cpu_pkg.sv */
// Shared constants, opcodes and controller/datapath interface types.
`timescale 1ns / 1ps
package acc_cpu_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int ITEM_ADDR_W   = 12;
    localparam int WORD_W        = 16;
    localparam int OPC_W         = 4;
    localparam int MODE_W        = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    localparam logic [OPC_W-1:0] OP_HALT  = 4'd0;
    localparam logic [OPC_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OPC_W-1:0] OP_STORE = 4'd2;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'd5;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd6;
    localparam logic [OPC_W-1:0] OP_JMP   = 4'd7;
    localparam logic [OPC_W-1:0] OP_JNEG  = 4'd8;

    localparam logic [1:0] ASEL_ITEM = 2'd0;
    localparam logic [1:0] ASEL_PC   = 2'd1;
    localparam logic [1:0] ASEL_OPND = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic [1:0] asel;
        logic       wr_item;
        logic       cap_read;
        logic       cap_instr;
        logic       exec;
        logic       restart;
        logic       reply;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              halted;
    } t_status;

endpackage

/* src/acc_cpu_ctrl.sv */
// Controller state machine sequencing memory accesses and instruction execution.
`timescale 1ns / 1ps
module acc_cpu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  acc_cpu_pkg::t_status i_status,
    output acc_cpu_pkg::t_cmd    o_cmd,
    output logic                 o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ACCESS = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_REPLY  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.asel = acc_cpu_pkg::ASEL_ITEM;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                case (i_status.mode)
                    acc_cpu_pkg::MODE_WRITE: begin
                        o_cmd.wr_item = 1'b1;
                        n_state = S_REPLY;
                    end
                    acc_cpu_pkg::MODE_READ: begin
                        n_state = S_DECODE;
                    end
                    acc_cpu_pkg::MODE_STEP: begin
                        o_cmd.asel = acc_cpu_pkg::ASEL_PC;
                        n_state = i_status.halted ? S_REPLY : S_DECODE;
                    end
                    default: begin
                        o_cmd.restart = 1'b1;
                        n_state = S_REPLY;
                    end
                endcase
            end
            S_DECODE: begin
                if (i_status.mode == acc_cpu_pkg::MODE_READ) begin
                    o_cmd.cap_read = 1'b1;
                    n_state = S_REPLY;
                end else begin
                    o_cmd.cap_instr = 1'b1;
                    o_cmd.asel = acc_cpu_pkg::ASEL_OPND;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                o_cmd.reply = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/acc_cpu_dp.sv */
// Datapath: item registers, word memory, accumulator, program counter and result registers.
`timescale 1ns / 1ps
module acc_cpu_dp #(
    parameter int ADDR_BITS = acc_cpu_pkg::ADDR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  acc_cpu_pkg::t_cmd                    i_cmd,
    input  logic [acc_cpu_pkg::MODE_W-1:0]       i_mode,
    input  logic [acc_cpu_pkg::ITEM_ADDR_W-1:0]  i_address,
    input  logic [acc_cpu_pkg::WORD_W-1:0]       i_data,
    output acc_cpu_pkg::t_status                 o_status,
    output logic                                 o_valid,
    output logic [acc_cpu_pkg::ITEM_ADDR_W-1:0]  o_pc,
    output logic signed [acc_cpu_pkg::WORD_W-1:0] o_acc,
    output logic                                 o_halted,
    output logic [acc_cpu_pkg::WORD_W-1:0]       o_read_data,
    output logic [acc_cpu_pkg::OPC_W-1:0]        o_opcode_done
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int WORD_W    = acc_cpu_pkg::WORD_W;
    localparam int OPC_W     = acc_cpu_pkg::OPC_W;

    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [WORD_W-1:0] r_mem_q;

    logic [acc_cpu_pkg::MODE_W-1:0] r_mode;
    logic [ADDR_BITS-1:0]           r_addr;
    logic [WORD_W-1:0]              r_data;
    logic [ADDR_BITS-1:0]           r_pc;
    logic [WORD_W-1:0]              r_acc;
    logic                           r_halted;
    logic [WORD_W-1:0]              r_instr;
    logic [WORD_W-1:0]              r_rdata;
    logic [OPC_W-1:0]               r_opdone;
    logic                           r_valid;

    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] target;
    logic [OPC_W-1:0]     opcode;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_W-1:0]    wr_data;

    assign opcode = r_instr[WORD_W-1 -: OPC_W];
    assign target = r_instr[ADDR_BITS-1:0];

    always_comb begin
        case (i_cmd.asel)
            acc_cpu_pkg::ASEL_PC:   rd_addr = r_pc;
            acc_cpu_pkg::ASEL_OPND: rd_addr = r_mem_q[ADDR_BITS-1:0];
            default:                rd_addr = r_addr;
        endcase
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_addr;
        wr_data = r_data;
        if (i_cmd.wr_item) begin
            mem_we = 1'b1;
        end else if (i_cmd.exec && opcode == acc_cpu_pkg::OP_STORE) begin
            mem_we  = 1'b1;
            wr_addr = target;
            wr_data = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_addr <= i_address[ADDR_BITS-1:0];
            r_data <= i_data;
        end
        if (i_cmd.cap_instr) begin
            r_instr <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_acc    <= '0;
            r_halted <= 1'b0;
            r_rdata  <= '0;
            r_opdone <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.reply;
            if (i_cmd.load_item) begin
                r_rdata  <= '0;
                r_opdone <= '0;
            end
            if (i_cmd.cap_read) begin
                r_rdata <= r_mem_q;
            end
            if (i_cmd.restart) begin
                r_pc     <= '0;
                r_acc    <= '0;
                r_halted <= 1'b0;
            end
            if (i_cmd.exec) begin
                r_opdone <= opcode;
                if (opcode == acc_cpu_pkg::OP_JMP
                        || (opcode == acc_cpu_pkg::OP_JNEG && r_acc[WORD_W-1])) begin
                    r_pc <= target;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
                case (opcode)
                    acc_cpu_pkg::OP_HALT: r_halted <= 1'b1;
                    acc_cpu_pkg::OP_LOAD: r_acc <= r_mem_q;
                    acc_cpu_pkg::OP_ADD:  r_acc <= r_acc + r_mem_q;
                    acc_cpu_pkg::OP_SUB:  r_acc <= r_acc - r_mem_q;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply) begin
            o_pc          <= acc_cpu_pkg::ITEM_ADDR_W'(r_pc);
            o_acc         <= r_acc;
            o_halted      <= r_halted;
            o_read_data   <= r_rdata;
            o_opcode_done <= r_opdone;
        end
    end

    assign o_valid         = r_valid;
    assign o_status.mode   = r_mode;
    assign o_status.halted = r_halted;

endmodule

/* src/accumulator_cpu_step.sv */
// Top level of the 16-bit accumulator processor with its internal word memory.
//
// Usage: drive i_mode, i_address and i_data and raise start; the item transfers
// at a rising edge where start is high and busy is low. Modes: write a memory
// word, read a memory word, execute one instruction, restart the processor.
// Each item gives one result, shown on the o_ ports for exactly one cycle with
// o_valid high; the receiver cannot hold results off and must take it then.
// After the transfer the controller passes through ACCESS and REPLY for write
// and restart, ACCESS, DECODE and REPLY for read, and ACCESS, DECODE, EXEC and
// REPLY for step (a step while halted skips DECODE and EXEC); the result is
// taken at the edge that ends the result cycle. Busy falls as the result appears,
// so the next item can transfer at that same edge. The sequence is set by the
// single memory port with registered read data: instruction fetch, operand
// read and execute or write-back each have a state of their own.
// Reset (synchronous, active low) clears program counter, accumulator, halt
// flag and control; the memory holds unknown contents until written and needs
// no clearing pass, so items are taken right after reset.
`timescale 1ns / 1ps
module accumulator_cpu_step #(
    parameter int ADDR_BITS = acc_cpu_pkg::ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [acc_cpu_pkg::MODE_W-1:0]        i_mode,
    input  logic [acc_cpu_pkg::ITEM_ADDR_W-1:0]   i_address,
    input  logic [acc_cpu_pkg::WORD_W-1:0]        i_data,
    output logic                                  o_valid,
    output logic [acc_cpu_pkg::ITEM_ADDR_W-1:0]   o_pc,
    output logic signed [acc_cpu_pkg::WORD_W-1:0] o_acc,
    output logic                                  o_halted,
    output logic [acc_cpu_pkg::WORD_W-1:0]        o_read_data,
    output logic [acc_cpu_pkg::OPC_W-1:0]         o_opcode_done
);

    acc_cpu_pkg::t_cmd    cmd;
    acc_cpu_pkg::t_status status;

    acc_cpu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !busy),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    acc_cpu_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_data        (i_data),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_pc          (o_pc),
        .o_acc         (o_acc),
        .o_halted      (o_halted),
        .o_read_data   (o_read_data),
        .o_opcode_done (o_opcode_done)
    );

endmodule
